### rtl/npn_canonical_form_macros.svh
// Assertion macros shared by the checker of the canonical-form block.
`ifndef NPN_CANONICAL_FORM_MACROS_SVH
`define NPN_CANONICAL_FORM_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define NPN_CHK_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, off while reset is high.
`define NPN_CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication that also holds across reset.
`define NPN_CHK_NEXT_ALL(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

### rtl/npn_pkg.sv
// Types, constants and table helpers of the canonical-form block.
package npn_pkg;

  typedef logic [31:0] tt_t;

  localparam int  NV_MAX    = 5;
  localparam tt_t FULL_MASK = 32'hFFFF_FFFF;

  localparam tt_t VAR_SIGN [NV_MAX] = '{
    32'hAAAA_AAAA, 32'hCCCC_CCCC, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'hFFFF_0000
  };

  localparam logic [2:0] CMD_N   = 3'd0;
  localparam logic [2:0] CMD_NN  = 3'd1;
  localparam logic [2:0] CMD_P   = 3'd2;
  localparam logic [2:0] CMD_NP  = 3'd3;
  localparam logic [2:0] CMD_NPN = 3'd4;

  // Valid table bits for a given variable count.
  function automatic tt_t table_mask(input logic [2:0] nv);
    tt_t r;
    unique case (nv)
      3'd0:    r = 32'h0000_0001;
      3'd1:    r = 32'h0000_0003;
      3'd2:    r = 32'h0000_000F;
      3'd3:    r = 32'h0000_00FF;
      3'd4:    r = 32'h0000_FFFF;
      default: r = FULL_MASK;
    endcase
    return r;
  endfunction

  // Swap the cofactors of every variable below nv whose phase bit is set.
  function automatic tt_t flip_inputs(input tt_t t, input logic [4:0] phase,
                                      input logic [2:0] nv);
    tt_t r;
    r = t;
    for (int v = 0; v < NV_MAX; v++) begin
      if (phase[v] && (v < int'(nv))) begin
        r = ((r & ~VAR_SIGN[v]) << (1 << v)) | ((r & VAR_SIGN[v]) >> (1 << v));
      end
    end
    return r & table_mask(nv);
  endfunction

endpackage

### rtl/npn_canonical_form.sv
// Per item: one load per output polarity and input phase that the mode allows, each load
// followed by Heap's walk over the variable orders when the mode permutes (n!-1 swaps plus
// the level resets and one exit step), else by one step; at most one swap per cycle.
// All swaps go through the single swap unit.
// One item at a time: busy is high from accept through done.
// Reset (synchronous, active high) returns the sequencer to idle.
module npn_canonical_form #(
  parameter int MAX_VARS = 5
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  input  logic [2:0]   cmd,
  input  logic [2:0]   num_vars,
  input  logic [31:0]  truth,
  output logic         done,
  output logic [31:0]  canon_truth
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_RUN  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t       state;
  logic [2:0]   nv;
  npn_pkg::tt_t tt;
  npn_pkg::tt_t cur;
  npn_pkg::tt_t best;
  logic         perm_on;
  logic         pol;
  logic         pol_last;
  logic [4:0]   phase;
  logic [4:0]   ph_last;
  logic [2:0]   hi;
  logic [2:0]   hc [npn_pkg::NV_MAX];
  logic         fresh;

  logic [2:0]   nv_in;
  logic [2:0]   cmd_c;
  logic         use_n;
  logic         use_c;
  logic         use_p;
  logic [2:0]   hc_i;
  npn_pkg::tt_t mask;
  npn_pkg::tt_t swapped;

  assign nv_in = (num_vars > 3'(MAX_VARS)) ? 3'(MAX_VARS) : num_vars;
  assign cmd_c = (cmd > npn_pkg::CMD_NPN) ? npn_pkg::CMD_NPN : cmd;
  assign use_n = (cmd_c != npn_pkg::CMD_P);
  assign use_c = (cmd_c == npn_pkg::CMD_NN) || (cmd_c == npn_pkg::CMD_NPN);
  assign use_p = (cmd_c >= npn_pkg::CMD_P);
  assign mask  = npn_pkg::table_mask(nv);
  assign hc_i  = (hi < 3'(npn_pkg::NV_MAX)) ? hc[hi] : 3'd0;

  // Heap's walk: odd level swaps with its counter, even level with variable 0.
  npn_var_swap u_swap (
    .tin   (cur),
    .var_a (hi[0] ? hc_i : 3'd0),
    .var_b (hi),
    .tout  (swapped)
  );

  assign busy        = (state != ST_IDLE);
  assign done        = (state == ST_DONE);
  assign canon_truth = best & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fresh <= 1'b0;
      hi    <= 3'd1;
      for (int k = 0; k < npn_pkg::NV_MAX; k++) hc[k] <= 3'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            nv       <= nv_in;
            tt       <= truth & npn_pkg::table_mask(nv_in);
            perm_on  <= use_p && (nv_in >= 3'd2);
            pol_last <= use_c;
            ph_last  <= use_n ? 5'((6'd1 << nv_in) - 6'd1) : 5'd0;
            pol      <= 1'b0;
            phase    <= 5'd0;
            best     <= npn_pkg::FULL_MASK;
            state    <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          cur   <= npn_pkg::flip_inputs(pol ? (~tt & mask) : tt, phase, nv);
          fresh <= 1'b1;
          hi    <= 3'd1;
          for (int k = 0; k < npn_pkg::NV_MAX; k++) hc[k] <= 3'd0;
          state <= ST_RUN;
        end
        ST_RUN: begin
          if (fresh && (cur < best)) best <= cur;
          priority if (!perm_on || (hi >= nv)) begin
            // walk over: advance phase, then polarity
            fresh <= 1'b0;
            if (phase != ph_last) begin
              phase <= phase + 5'd1;
              state <= ST_LOAD;
            end else if (pol != pol_last) begin
              pol   <= 1'b1;
              phase <= 5'd0;
              state <= ST_LOAD;
            end else begin
              state <= ST_DONE;
            end
          end else if (hc_i < hi) begin
            cur    <= swapped;
            fresh  <= 1'b1;
            hc[hi] <= hc_i + 3'd1;
            hi     <= 3'd1;
          end else begin
            hc[hi] <= 3'd0;
            hi     <= hi + 3'd1;
            fresh  <= 1'b0;
          end
        end
        ST_DONE: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/npn_var_swap.sv
// Exchange of two input variables of a truth table.
module npn_var_swap (
  input  npn_pkg::tt_t tin,
  input  logic [2:0]   var_a,
  input  logic [2:0]   var_b,
  output npn_pkg::tt_t tout
);

  always_comb begin
    logic [4:0] mi;
    logic [4:0] src;
    tout = '0;
    for (int m = 0; m < 32; m++) begin
      mi         = 5'(m);
      src        = mi;
      src[var_a] = mi[var_b];
      src[var_b] = mi[var_a];
      tout[m]    = tin[src];
    end
  end

endmodule

### rtl/npn_checker.sv
// Port-level checks of the canonical-form block, bound to the top level.
`include "npn_canonical_form_macros.svh"

module npn_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] canon_truth
);

  `NPN_CHK_SAME(a_done_busy, clk, rst, done, busy)
  `NPN_CHK_NEXT(a_done_single, clk, rst, done, !done && !busy)
  `NPN_CHK_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !done)
  `NPN_CHK_NEXT_ALL(a_reset_idle, clk, rst, !busy && !done)
  `NPN_CHK_SAME(a_result_known, clk, rst, done, !$isunknown(canon_truth))

endmodule

bind npn_canonical_form npn_checker u_npn_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .canon_truth (canon_truth)
);

### bench/npn_canonical_form_check.sv
// Checker for the canonical-form block: predicts each item's minimum table and compares results.
module npn_canonical_form_check
  import npn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  cmd,
  input  logic [2:0]  num_vars,
  input  tt_t         truth,
  input  logic        done,
  input  tt_t         canon_truth,
  output int          errors,
  output int          pending,
  output int          checked
);

  tt_t canon_q[$];

  initial begin
    errors  = 0;
    pending = 0;
    checked = 0;
  end

  // Exhaustive search over the transforms that the mode allows.
  function automatic tt_t npn_min_table(input logic [2:0] mode, input logic [2:0] nv_in,
                                        input tt_t t_in);
    int         nv, nm, nphase, npol, total, code, used, pv;
    bit         use_n, use_c, use_p, ok;
    logic [2:0] m_eff;
    tt_t        msk, t, base, cand, best;
    int         dest [32];
    int         perm [5];
    nv = (int'(nv_in) > NV_MAX) ? NV_MAX : int'(nv_in);
    nm = 1 << nv;
    msk = (nv == NV_MAX) ? FULL_MASK : ((32'd1 << nm) - 32'd1);
    t = t_in & msk;
    m_eff = (mode > CMD_NPN) ? CMD_NPN : mode;
    use_n = (m_eff != CMD_P);
    use_c = (m_eff == CMD_NN) || (m_eff == CMD_NPN);
    use_p = (m_eff == CMD_P) || (m_eff == CMD_NP) || (m_eff == CMD_NPN);
    nphase = use_n ? nm : 1;
    npol = use_c ? 2 : 1;
    total = 1;
    if (use_p) begin
      for (int v = 0; v < nv; v++) total *= nv;
    end
    best = FULL_MASK;
    for (int idx = 0; idx < total; idx++) begin
      code = idx;
      used = 0;
      ok = 1'b1;
      for (int v = 0; v < nv; v++) begin
        if (use_p) begin
          perm[v] = code % nv;
          code = code / nv;
        end else begin
          perm[v] = v;
        end
        if (((used >> perm[v]) & 1) != 0) ok = 1'b0;
        used |= 1 << perm[v];
      end
      if (ok) begin
        // Minterm m lands at dest[m] under this permutation.
        for (int m = 0; m < nm; m++) begin
          pv = 0;
          for (int v = 0; v < nv; v++) begin
            if (((m >> v) & 1) != 0) pv |= 1 << perm[v];
          end
          dest[m] = pv;
        end
        for (int c = 0; c < npol; c++) begin
          base = (c != 0) ? (~t & msk) : t;
          for (int p = 0; p < nphase; p++) begin
            // Negating the inputs in p reads minterm m from m ^ p.
            cand = '0;
            for (int m = 0; m < nm; m++) begin
              if (base[m ^ p]) cand[dest[m]] = 1'b1;
            end
            if (cand < best) best = cand;
          end
        end
      end
    end
    return best & msk;
  endfunction

  task automatic report_mismatch(input string what, input tt_t got, input tt_t want);
    $display("%0t: MISMATCH %s: got %08h expected %08h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        canon_q.push_back(npn_min_table(cmd, num_vars, truth));
      end
      if (done) begin
        if (canon_q.size() == 0) begin
          report_mismatch("result with no item outstanding", canon_truth, '0);
        end else begin
          tt_t want;
          want = canon_q.pop_front();
          if (canon_truth !== want) report_mismatch("canon_truth", canon_truth, want);
          checked <= checked + 1;
        end
      end
    end
    pending <= canon_q.size();
  end

endmodule

### bench/tb_npn_canonical_form.sv
// Top of the canonical-form bench: clock, reset, item stimulus and verdict.
module tb_npn_canonical_form;
  import npn_pkg::*;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic [2:0] cmd;
  logic [2:0] num_vars;
  tt_t        truth;
  logic       done;
  tt_t        canon_truth;

  int errors, pending, checked;
  int sent;
  int per_mode [8];
  int per_nv [8];

  npn_canonical_form #(.MAX_VARS(NV_MAX)) dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .num_vars    (num_vars),
    .truth       (truth),
    .done        (done),
    .canon_truth (canon_truth)
  );

  npn_canonical_form_check cmp (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .num_vars    (num_vars),
    .truth       (truth),
    .done        (done),
    .canon_truth (canon_truth),
    .errors      (errors),
    .pending     (pending),
    .checked     (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hold start until the block takes the item.
  task automatic issue(input logic [2:0] c, input logic [2:0] n, input tt_t t);
    start    <= 1'b1;
    cmd      <= c;
    num_vars <= n;
    truth    <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    per_mode[c]++;
    per_nv[n]++;
  endtask

  // Drop start and scramble the fields while idle.
  task automatic idle_for(input int n);
    start    <= 1'b0;
    cmd      <= 3'($urandom);
    num_vars <= 3'($urandom);
    truth    <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_mode;
    if ($urandom_range(99) < 85) return 3'($urandom_range(CMD_NPN));
    return 3'($urandom_range(7, 5));
  endfunction

  // Mostly small variable counts; five and above stay rare since they are slow.
  function automatic logic [2:0] pick_nv;
    int r;
    r = $urandom_range(99);
    if (r < 5)  return 3'd0;
    if (r < 15) return 3'd1;
    if (r < 30) return 3'd2;
    if (r < 55) return 3'd3;
    if (r < 85) return 3'd4;
    if (r < 95) return 3'd5;
    return 3'($urandom_range(7, 6));
  endfunction

  function automatic tt_t pick_table;
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 10) return FULL_MASK;
    if (r < 20) return 32'd1 << $urandom_range(31);
    if (r < 30) return ~(32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  initial begin
    int burst, k;
    rst      <= 1'b1;
    start    <= 1'b0;
    cmd      <= CMD_N;
    num_vars <= 3'd0;
    truth    <= '0;
    sent = 0;
    foreach (per_mode[i]) per_mode[i] = 0;
    foreach (per_nv[i]) per_nv[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Every mode on a three-variable table.
    issue(CMD_N,   3'd3, $urandom);
    issue(CMD_NN,  3'd3, $urandom);
    issue(CMD_P,   3'd3, $urandom);
    issue(CMD_NP,  3'd3, $urandom);
    issue(CMD_NPN, 3'd3, $urandom);
    // No variables or one: with none, only the output complement can change the single bit.
    issue(CMD_N,   3'd0, 32'h0000_0001);
    issue(CMD_NN,  3'd0, 32'h0000_0001);
    issue(CMD_NPN, 3'd0, FULL_MASK);
    issue(CMD_P,   3'd0, 32'hFFFF_FFFE);
    issue(CMD_N,   3'd1, 32'h0000_0002);
    issue(CMD_P,   3'd1, 32'h0000_0002);
    // Unused table bits above the variable count, then four- and five-variable tables.
    issue(CMD_NN,  3'd2, FULL_MASK);
    issue(CMD_NP,  3'd2, 32'hFFFF_FFF8);
    issue(CMD_NPN, 3'd5, '0);
    issue(CMD_NPN, 3'd5, FULL_MASK);
    issue(CMD_P,   3'd5, $urandom);
    issue(CMD_NPN, 3'd4, $urandom);
    // Variable counts above the limit act as the limit.
    issue(CMD_NP,  3'd6, $urandom);
    issue(CMD_NPN, 3'd7, $urandom);
    // Mode codes past the last act as full NPN.
    issue(3'd5, 3'd4, $urandom);
    issue(3'd6, 3'd3, $urandom);
    issue(3'd7, 3'd2, $urandom);
    drain();

    k = 0;
    while (k < 100) begin
      burst = $urandom_range(8, 1);
      for (int b = 0; b < burst && k < 100; b++) begin
        issue(pick_mode(), pick_nv(), pick_table());
        k++;
      end
      if (k >= 50 && k - burst < 50) begin
        drain();
      end else if ($urandom_range(3) != 0) begin
        idle_for($urandom_range(20, 1));
      end
    end

    drain();
    repeat (64) @(posedge clk);
    $display("sent %0d items: N %0d, NN %0d, P %0d, NP %0d, NPN %0d, alias codes %0d; checked %0d",
             sent, per_mode[0], per_mode[1], per_mode[2], per_mode[3], per_mode[4],
             per_mode[5] + per_mode[6] + per_mode[7], checked);
    $display("variable counts 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             per_nv[0], per_nv[1], per_nv[2], per_nv[3], per_nv[4], per_nv[5], per_nv[6],
             per_nv[7]);
    if (errors == 0 && pending == 0) begin
      $display("tb_npn_canonical_form: done, clean");
    end else begin
      $display("tb_npn_canonical_form: done, errors");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("tb_npn_canonical_form: done, errors");
    $finish;
  end

endmodule
